>>> sv/lidar_scan_cluster_centroids_assert.svh
// Assertion macros shared by the cluster centroid block.
`ifndef LIDAR_SCAN_CLUSTER_CENTROIDS_ASSERT_SVH
`define LIDAR_SCAN_CLUSTER_CENTROIDS_ASSERT_SVH
`ifndef ASSERT_OFF
`define LSCC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("lscc check failed");
`define LSCC_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("lscc check failed");
`else
`define LSCC_ASSERT(lbl, prop)
`define LSCC_NEVER(lbl, expr)
`endif
`endif

>>> sv/lscc_pkg.sv
package lscc_pkg;

  localparam int MAX_BEAMS       = 2048;
  localparam int RANGE_BITS      = 16;
  localparam int TRIG_TABLE_BITS = 10;
  localparam int COORD_BITS      = 32;

  localparam int SUM_BITS   = 40;
  localparam int CNT_BITS   = 12;
  localparam int FULL_COUNT = (MAX_BEAMS < 4095) ? MAX_BEAMS : 4095;
  localparam int ADDR_BITS  = 5;

  localparam int QBITS   = TRIG_TABLE_BITS - 2;
  localparam int QUARTER = 1 << QBITS;

  // A centroid coordinate is an average of points no larger than the range.
  localparam int POINT_BITS = RANGE_BITS + 2;
  localparam int MUL_W      = (POINT_BITS > 18) ? POINT_BITS : 18;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ACC_W      = PROD_W + 1;
  localparam int OUT_BITS   = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int WIDE_W     = 34;

  typedef enum logic [2:0] {
    REG_JUMP_THRESHOLD = 3'd0,
    REG_MIN_RANGE      = 3'd1,
    REG_MAX_RANGE      = 3'd2,
    REG_START_ANGLE    = 3'd3,
    REG_ANGLE_STEP     = 3'd4
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_BETA,
    S_ANG,
    S_LOOK,
    S_PX,
    S_PY,
    S_PACC,
    S_DIV_X,
    S_WAIT_X,
    S_WAIT_Y,
    S_NOPOSE,
    S_LOOK_P,
    S_RX1,
    S_RX2,
    S_RX3,
    S_RY1,
    S_RY2,
    S_OUT,
    S_DONE
  } state_t;

  typedef logic [15:0] qtab_t [0:QUARTER];

  function automatic qtab_t build_qtab();
    qtab_t t;
    longint unsigned z, z2, u, y;
    for (int r = 0; r <= QUARTER; r++) begin
      z  = longint'(r) << (15 - QBITS);
      z2 = (z * z) >> 15;
      u  = (64'd2320 * z2) >> 15;
      u  = 64'd21024 - u;
      u  = (u * z2) >> 15;
      u  = 64'd51472 - u;
      y  = (u * z) >> 15;
      if (y > 64'd32767) y = 64'd32767;
      t[r] = 16'(y);
    end
    return t;
  endfunction

  localparam qtab_t SIN_QTAB = build_qtab();

  function automatic logic signed [15:0] sin_lu(logic [15:0] angle);
    logic [TRIG_TABLE_BITS-1:0] k;
    logic [1:0] quad;
    logic [QBITS:0] ri;
    logic signed [15:0] y;
    k    = angle[15 -: TRIG_TABLE_BITS];
    quad = k[TRIG_TABLE_BITS-1 -: 2];
    ri   = {1'b0, k[QBITS-1:0]};
    if (quad[0]) ri = (QBITS + 1)'(QUARTER) - ri;
    y = signed'(SIN_QTAB[ri]);
    return quad[1] ? -y : y;
  endfunction

  function automatic logic signed [15:0] cos_lu(logic [15:0] angle);
    return sin_lu(angle + 16'h4000);
  endfunction

  // Round half up after a Q15 product: floor((v + 2^14) / 2^15).
  function automatic logic signed [ACC_W-1:0] rnd15(logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] half;
    half = ACC_W'(16384);
    return (v + half) >>> 15;
  endfunction

  function automatic logic [31:0] sat_out(logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi, lo, c;
    hi = WIDE_W'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
    lo = -hi - WIDE_W'(1);
    c  = v;
    if (v > hi) c = hi;
    if (v < lo) c = lo;
    return c[31:0];
  endfunction

endpackage

>>> sv/lscc_div.sv
module lscc_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [lscc_pkg::SUM_BITS-1:0] dividend,
  input  logic        [lscc_pkg::CNT_BITS-1:0] divisor,
  output logic                                 busy,
  output logic                                 done,
  output logic signed [lscc_pkg::SUM_BITS-1:0] quotient
);
  import lscc_pkg::*;

  localparam int STEP_W = $clog2(SUM_BITS + 1);

  logic [CNT_BITS-1:0] rem;
  logic [SUM_BITS-1:0] quo;
  logic [STEP_W-1:0]   step;
  logic                neg;
  logic [CNT_BITS:0]   trial;
  logic                fits;

  assign busy     = (step != '0);
  assign trial    = {rem, quo[SUM_BITS-1]};
  assign fits     = (trial >= {1'b0, divisor});
  assign quotient = neg ? -signed'(quo) : signed'(quo);

  // Restoring division on magnitudes, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == STEP_W'(1));
      if (start) begin
        step <= STEP_W'(SUM_BITS);
        rem  <= '0;
        neg  <= dividend[SUM_BITS-1];
        quo  <= dividend[SUM_BITS-1] ? unsigned'(-dividend) : unsigned'(dividend);
      end else if (busy) begin
        step <= step - STEP_W'(1);
        rem  <= fits ? CNT_BITS'(trial - {1'b0, divisor}) : trial[CNT_BITS-1:0];
        quo  <= {quo[SUM_BITS-2:0], fits};
      end
    end
  end

endmodule

>>> sv/lidar_scan_cluster_centroids.sv
// Channel  Direction  Handshake          Payload
// input    in         in_valid/in_stall  range, finite, index, last, pose
// output   out        out_valid/out_stall obstacle x/y, last_of_run
// config   in/out     APB psel/penable   five 16-bit registers at 4*i
// A beam is taken only in idle; in_stall stays high until the beam, and any
// cluster that it closes, is finished and the block is back in idle.
// Each closed cluster needs two divisions on the shared divider and, with a
// known pose, the rotation on the shared 18x18 multiplier; the result is held
// while out_stall is high.
// Reset is synchronous, empties the open cluster and holds in_stall high.
module lidar_scan_cluster_centroids (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [15:0]                      range_mm,
  input  logic                             range_finite,
  input  logic [10:0]                      beam_index,
  input  logic                             last_beam,
  input  logic signed [31:0]               pose_x_mm,
  input  logic signed [31:0]               pose_y_mm,
  input  logic signed [15:0]               pose_yaw,
  input  logic                             pose_known,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [31:0]               obstacle_x_mm,
  output logic signed [31:0]               obstacle_y_mm,
  output logic                             last_of_run,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lscc_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import lscc_pkg::*;

  `include "lidar_scan_cluster_centroids_assert.svh"

  logic [15:0] jump_threshold_mm, min_range_mm, max_range_mm, start_angle, angle_step;
  reg_idx_t    reg_sel;

  state_t state, state_next;

  logic [15:0]        r_q, prev_range;
  logic               finite_q, last_q, pk_q;
  logic [10:0]        idx_q;
  logic signed [31:0] px_q, py_q;
  logic [15:0]        yaw_q;

  logic signed [SUM_BITS-1:0] sum_x, sum_y;
  logic [CNT_BITS-1:0]        cluster_count;
  logic                       add_q, phase_q;

  logic [15:0]                trig_angle;
  logic signed [15:0]         sin_v, cos_v;
  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc, prod_ext, rnd_p, rnd_d, rnd_s;
  logic signed [POINT_BITS-1:0] cx, cy;

  logic                       div_start, div_busy, div_done;
  logic signed [SUM_BITS-1:0] div_a, div_q;

  logic        valid_beam, jump, close_first;
  logic [15:0] diff;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      jump_threshold_mm <= 16'd300;
      min_range_mm      <= 16'd0;
      max_range_mm      <= 16'hFFFF;
      start_angle       <= 16'h8000;
      angle_step        <= 16'd32;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_JUMP_THRESHOLD: jump_threshold_mm <= pwdata[15:0];
        REG_MIN_RANGE:      min_range_mm      <= pwdata[15:0];
        REG_MAX_RANGE:      max_range_mm      <= pwdata[15:0];
        REG_START_ANGLE:    start_angle       <= pwdata[15:0];
        REG_ANGLE_STEP:     angle_step        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_JUMP_THRESHOLD: prdata = {16'd0, jump_threshold_mm};
      REG_MIN_RANGE:      prdata = {16'd0, min_range_mm};
      REG_MAX_RANGE:      prdata = {16'd0, max_range_mm};
      REG_START_ANGLE:    prdata = {16'd0, start_angle};
      REG_ANGLE_STEP:     prdata = {16'd0, angle_step};
      default:            prdata = '0;
    endcase
  end

  assign valid_beam = finite_q && (r_q > min_range_mm) && (r_q <= max_range_mm)
                      && (32'(idx_q) < MAX_BEAMS);
  assign diff  = (r_q > prev_range) ? r_q - prev_range : prev_range - r_q;
  assign jump  = (diff > jump_threshold_mm) || (cluster_count >= CNT_BITS'(FULL_COUNT));
  assign close_first = (cluster_count != '0) && (!valid_beam || jump);

  assign in_stall  = rst || (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  assign div_a = (state == S_DIV_X) ? sum_x : sum_y;

  lscc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (cluster_count),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_BETA: begin
        mul_a = MUL_W'(idx_q);
        mul_b = MUL_W'(angle_step);
      end
      S_PX: begin
        mul_a = MUL_W'(r_q);
        mul_b = MUL_W'(cos_v);
      end
      S_PY: begin
        mul_a = MUL_W'(r_q);
        mul_b = MUL_W'(sin_v);
      end
      S_RX1: begin
        mul_a = MUL_W'(cos_v);
        mul_b = MUL_W'(cx);
      end
      S_RX2: begin
        mul_a = MUL_W'(sin_v);
        mul_b = MUL_W'(cy);
      end
      S_RX3: begin
        mul_a = MUL_W'(sin_v);
        mul_b = MUL_W'(cx);
      end
      S_RY1: begin
        mul_a = MUL_W'(cos_v);
        mul_b = MUL_W'(cy);
      end
      default: ;
    endcase
  end

  assign prod_ext = ACC_W'(prod);
  assign rnd_p    = rnd15(prod_ext);
  assign rnd_d    = rnd15(acc - prod_ext);
  assign rnd_s    = rnd15(acc + prod_ext);

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_CHECK;
      S_CHECK: begin
        if (close_first) state_next = S_DIV_X;
        else if (valid_beam) state_next = S_BETA;
        else if (last_q && cluster_count != '0) state_next = S_DIV_X;
        else state_next = S_DONE;
      end
      S_BETA:   state_next = S_ANG;
      S_ANG:    state_next = S_LOOK;
      S_LOOK:   state_next = S_PX;
      S_PX:     state_next = S_PY;
      S_PY:     state_next = S_PACC;
      S_PACC:   state_next = last_q ? S_DIV_X : S_DONE;
      S_DIV_X: begin
        div_start  = 1'b1;
        state_next = S_WAIT_X;
      end
      S_WAIT_X: begin
        if (div_done) begin
          div_start  = 1'b1;
          state_next = S_WAIT_Y;
        end
      end
      S_WAIT_Y: if (div_done) state_next = pk_q ? S_LOOK_P : S_NOPOSE;
      S_NOPOSE: state_next = S_OUT;
      S_LOOK_P: state_next = S_RX1;
      S_RX1:    state_next = S_RX2;
      S_RX2:    state_next = S_RX3;
      S_RX3:    state_next = S_RY1;
      S_RY1:    state_next = S_RY2;
      S_RY2:    state_next = S_OUT;
      S_OUT: begin
        if (!out_stall) begin
          if (!phase_q && add_q) state_next = S_BETA;
          else state_next = S_DONE;
        end
      end
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x         <= '0;
      sum_y         <= '0;
      cluster_count <= '0;
      prev_range    <= '0;
    end else begin
      prod <= mul_a * mul_b;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            r_q      <= range_mm & 16'((64'd1 << RANGE_BITS) - 64'd1);
            finite_q <= range_finite;
            idx_q    <= beam_index;
            last_q   <= last_beam;
            px_q     <= pose_x_mm;
            py_q     <= pose_y_mm;
            yaw_q    <= pose_yaw;
            pk_q     <= pose_known;
          end
        end
        S_CHECK: begin
          add_q <= valid_beam;
          // A close ahead of the beam is the last result unless the last
          // beam will close the cluster that this beam opens.
          phase_q     <= !close_first;
          last_of_run <= close_first ? !(valid_beam && last_q) : 1'b1;
        end
        S_ANG:  trig_angle <= start_angle + prod[15:0];
        S_LOOK, S_LOOK_P: begin
          sin_v <= sin_lu(trig_angle);
          cos_v <= cos_lu(trig_angle);
        end
        S_PY:   sum_x <= sum_x + SUM_BITS'(rnd_p);
        S_PACC: begin
          sum_y         <= sum_y + SUM_BITS'(rnd_p);
          cluster_count <= cluster_count + CNT_BITS'(1);
          prev_range    <= r_q;
          phase_q       <= 1'b1;
          last_of_run   <= 1'b1;
        end
        S_WAIT_X: if (div_done) cx <= div_q[POINT_BITS-1:0];
        S_WAIT_Y: begin
          if (div_done) begin
            cy         <= div_q[POINT_BITS-1:0];
            trig_angle <= yaw_q;
          end
        end
        S_NOPOSE: begin
          obstacle_x_mm <= sat_out(WIDE_W'(cx));
          obstacle_y_mm <= sat_out(WIDE_W'(cy));
        end
        S_RX2:  acc <= prod_ext;
        S_RX3:  obstacle_x_mm <= sat_out(WIDE_W'(px_q) + WIDE_W'(rnd_d));
        S_RY1:  acc <= prod_ext;
        S_RY2:  obstacle_y_mm <= sat_out(WIDE_W'(py_q) + WIDE_W'(rnd_s));
        S_OUT: begin
          if (!out_stall) begin
            sum_x         <= '0;
            sum_y         <= '0;
            cluster_count <= '0;
          end
        end
        S_DONE: if (last_q) prev_range <= '0;
        default: ;
      endcase
    end
  end

  `LSCC_ASSERT(a_result_blocks_input, out_valid |-> in_stall)
  `LSCC_NEVER(a_count_limit, cluster_count > CNT_BITS'(FULL_COUNT))
  `LSCC_ASSERT(a_div_in_wait, div_busy |-> (state == S_WAIT_X || state == S_WAIT_Y))
  `LSCC_ASSERT(a_no_empty_close, (state == S_DIV_X) |-> (cluster_count != '0))

endmodule
